// File: rtl/olst_pkg.sv
// olst_pkg: shared constants for the ordered array list.
// Field widths, operation codes and parameter defaults. No dependencies.
package olst_pkg;

  localparam int FUNC_W     = 3;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 8;
  localparam int CAP_W      = 8;

  localparam int DEPTH_DEF  = 128;
  localparam int DATA_W_DEF = 32;
  localparam int CNT_MAX    = 255;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_READ   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] OP_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

endpackage

// File: rtl/olst_in_if.sv
// olst_in_if: request channel, one operation word per handshake.
// Depends on olst_pkg for field widths.
interface olst_in_if;
  logic                         valid;
  logic                         ready;
  logic [olst_pkg::FUNC_W-1:0]  func;
  logic [olst_pkg::POS_W-1:0]   position;
  logic [olst_pkg::VAL_W-1:0]   element_value;

  modport source (output valid, func, position, element_value, input ready);
  modport sink   (input valid, func, position, element_value, output ready);
endinterface

// File: rtl/olst_out_if.sv
// olst_out_if: result channel, one result word per handshake.
// Depends on olst_pkg for field widths.
interface olst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [olst_pkg::VAL_W-1:0]   read_value;
  logic [olst_pkg::POS_W-1:0]   found_position;
  logic [olst_pkg::CNT_W-1:0]   list_length;

  modport source (output valid, ok, read_value, found_position, list_length, input ready);
  modport sink   (input valid, ok, read_value, found_position, list_length, output ready);
endinterface

// File: rtl/olst_ram.sv
// olst_ram: entry storage, one write port and one read port, registered read.
// No package dependencies.
module olst_ram #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/olst_ctrl.sv
// olst_ctrl: operation sequencer; decodes a request, walks the entry RAM
// one entry per cycle for shifts and searches, and holds the result word.
// Depends on olst_pkg, olst_in_if, olst_out_if.
module olst_ctrl #(
  parameter int DEPTH      = olst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = olst_pkg::DATA_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [olst_pkg::CAP_W-1:0]    cap_i,
  olst_in_if.sink                       in_if,
  olst_out_if.source                    out_if,
  output logic                          ram_we,
  output logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic [DATA_WIDTH-1:0]         ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(DEPTH)-1:0]      ram_raddr,
  input  logic [DATA_WIDTH-1:0]         ram_rdata
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = olst_pkg::CNT_W;
  localparam int VW       = olst_pkg::VAL_W;
  localparam int CAP_CEIL = (DEPTH < olst_pkg::CNT_MAX) ? DEPTH : olst_pkg::CNT_MAX;
  localparam logic [CW-1:0] CAP_CEIL_B = CW'(CAP_CEIL);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_DONE} state_t;
  typedef enum logic [1:0] {MD_READ, MD_SHR, MD_SHL, MD_FIND} mode_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]     pos_m1_r, pos_m1_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [VW-1:0]     res_rv_r, res_rv_nxt;
  logic [CW-1:0]     res_fp_r, res_fp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [VW-1:0]     out_rv_r, out_rv_nxt;
  logic [CW-1:0]     out_fp_r, out_fp_nxt;
  logic [CW-1:0]     out_len_r, out_len_nxt;

  logic [CW-1:0]     pos_in;
  logic [CW-1:0]     pos_dec;
  logic              pos_nz;
  logic              pos_le_cnt;
  logic              pos_le_cnt1;
  logic              room;
  logic [CW-1:0]     fp_none;

  assign in_if.ready           = (state_r == ST_IDLE);
  assign out_if.valid          = out_valid_r;
  assign out_if.ok             = out_ok_r;
  assign out_if.read_value     = out_rv_r;
  assign out_if.found_position = out_fp_r;
  assign out_if.list_length    = out_len_r;

  assign pos_in      = in_if.position;
  assign pos_dec     = pos_in - 8'd1;
  assign pos_nz      = (pos_in != 8'd0);
  assign pos_le_cnt  = (pos_in <= cnt_r);
  assign pos_le_cnt1 = ({1'b0, pos_in} <= ({1'b0, cnt_r} + 9'd1));
  assign room        = (cnt_r < cap_i);
  assign fp_none     = (cnt_r == 8'hFF) ? 8'hFF : cnt_r + 8'd1;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    rd_addr_nxt   = rd_addr_r;
    wr_addr_nxt   = wr_addr_r;
    pos_m1_nxt    = pos_m1_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    res_ok_nxt    = res_ok_r;
    res_rv_nxt    = res_rv_r;
    res_fp_nxt    = res_fp_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_rv_nxt    = out_rv_r;
    out_fp_nxt    = out_fp_r;
    out_len_nxt   = out_len_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_addr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_addr_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          key_nxt    = DATA_WIDTH'(in_if.element_value);
          pos_m1_nxt = AW'(pos_dec);
          res_ok_nxt = 1'b0;
          res_rv_nxt = '0;
          res_fp_nxt = '0;
          state_nxt  = ST_DONE;
          unique case (in_if.func)
            olst_pkg::OP_INSERT: begin
              if (pos_nz && pos_le_cnt1 && room) begin
                res_ok_nxt = 1'b1;
                cnt_nxt    = cnt_r + 8'd1;
                if (pos_le_cnt) begin
                  mode_nxt    = MD_SHR;
                  rd_addr_nxt = AW'(cnt_r - 8'd1);
                  wr_addr_nxt = AW'(cnt_r);
                  rem_nxt     = cnt_r - pos_in + 8'd1;
                  state_nxt   = ST_SCAN;
                end else begin
                  state_nxt = ST_WRITE;
                end
              end
            end
            olst_pkg::OP_READ: begin
              if (pos_nz && pos_le_cnt) begin
                res_ok_nxt  = 1'b1;
                mode_nxt    = MD_READ;
                rd_addr_nxt = AW'(pos_dec);
                rem_nxt     = 8'd1;
                state_nxt   = ST_SCAN;
              end
            end
            olst_pkg::OP_REMOVE: begin
              if (pos_nz && pos_le_cnt) begin
                res_ok_nxt = 1'b1;
                cnt_nxt    = cnt_r - 8'd1;
                if (pos_in < cnt_r) begin
                  mode_nxt    = MD_SHL;
                  rd_addr_nxt = AW'(pos_in);
                  wr_addr_nxt = AW'(pos_dec);
                  rem_nxt     = cnt_r - pos_in;
                  state_nxt   = ST_SCAN;
                end
              end
            end
            olst_pkg::OP_FIND: begin
              res_ok_nxt = 1'b1;
              res_fp_nxt = fp_none;
              if (cnt_r != 8'd0) begin
                mode_nxt    = MD_FIND;
                rd_addr_nxt = '0;
                wr_addr_nxt = '0;
                rem_nxt     = cnt_r;
                state_nxt   = ST_SCAN;
              end
            end
            olst_pkg::OP_CLEAR: begin
              res_ok_nxt = 1'b1;
              res_fp_nxt = 8'd1;
              cnt_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rem_r != 8'd0) begin
          ram_re      = 1'b1;
          rem_nxt     = rem_r - 8'd1;
          rd_addr_nxt = (mode_r == MD_SHR) ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          case (mode_r)
            MD_SHR: begin
              ram_we      = 1'b1;
              wr_addr_nxt = wr_addr_r - AW'(1);
            end
            MD_SHL: begin
              ram_we      = 1'b1;
              wr_addr_nxt = wr_addr_r + AW'(1);
            end
            MD_READ: begin
              res_rv_nxt = VW'(ram_rdata);
            end
            MD_FIND: begin
              wr_addr_nxt = wr_addr_r + AW'(1);
            end
            default: begin
            end
          endcase
          if (rem_r == 8'd0) begin
            state_nxt = (mode_r == MD_SHR) ? ST_WRITE : ST_DONE;
          end
          if ((mode_r == MD_FIND) && (ram_rdata == key_r)) begin
            res_fp_nxt = CW'(wr_addr_r) + 8'd1;
            pend_nxt   = 1'b0;
            state_nxt  = ST_DONE;
          end
        end
      end

      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1_r;
        ram_wdata = key_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_rv_nxt    = res_rv_r;
          out_fp_nxt    = res_fp_r;
          out_len_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      rd_addr_r   <= rd_addr_nxt;
      wr_addr_r   <= wr_addr_nxt;
      pos_m1_r    <= pos_m1_nxt;
      rem_r       <= rem_nxt;
      key_r       <= key_nxt;
      res_ok_r    <= res_ok_nxt;
      res_rv_r    <= res_rv_nxt;
      res_fp_r    <= res_fp_nxt;
      out_ok_r    <= out_ok_nxt;
      out_rv_r    <= out_rv_nxt;
      out_fp_r    <= out_fp_nxt;
      out_len_r   <= out_len_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CEIL_B)
    else $error("entry count above capacity ceiling");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("RAM read outstanding while idle");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && (in_if.func == olst_pkg::OP_CLEAR)) |=> (cnt_r == 8'd0))
    else $error("clear did not empty the list");

  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_WRITE) || (pend_r && (state_r == ST_SCAN))))
    else $error("RAM write outside shift or insert");
`endif

endmodule

// File: rtl/ordered_array_list.sv
// ordered_array_list: ordered list of words in a single-port-pair RAM, 1-based positions.
// Each request walks the RAM over the n entries it touches, one per cycle; an insert that
// shifts then writes the new entry, a read touches one entry, clear and refusals none.
// The longest requests are set by the shift / search walk over the RAM port.
// Reset (synchronous, rst_n low): list empty, capacity 100; RAM contents are not cleared.
// Depends on olst_pkg, olst_in_if, olst_out_if, olst_ram, olst_ctrl.
module ordered_array_list #(
  parameter int DEPTH      = olst_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = olst_pkg::DATA_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  olst_in_if.sink                     in_if,
  olst_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [olst_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CAP_W    = olst_pkg::CAP_W;
  localparam int CAP_CEIL = (DEPTH < olst_pkg::CNT_MAX) ? DEPTH : olst_pkg::CNT_MAX;
  localparam logic [CAP_W-1:0] CAP_CEIL_B = CAP_W'(CAP_CEIL);

  logic [CAP_W-1:0]      cap_r;
  logic [CAP_W-1:0]      cap_eff;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= olst_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_eff = (cap_r > CAP_CEIL_B) ? CAP_CEIL_B : cap_r;

  olst_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_i     (cap_eff),
    .in_if     (in_if),
    .out_if    (out_if),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  olst_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: sim/tb_ordered_array_list.sv
// tb_ordered_array_list: self-checking bench for the ordered array list.
// Uses olst_pkg, olst_in_if, olst_out_if and the ordered_array_list RTL; it keeps
// its own shadow list and checks every result word against it.
`timescale 1ns / 1ps

module tb_ordered_array_list;

  typedef logic [olst_pkg::FUNC_W-1:0] func_t;
  typedef logic [olst_pkg::POS_W-1:0]  pos_t;

  localparam int DEPTH          = olst_pkg::DEPTH_DEF;
  localparam int DRAIN_CYCLES   = DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_SEG  = 300;
  localparam int NUM_SEGS       = 6;
  localparam func_t OP_TOP      = '1;

  typedef struct packed {
    logic [olst_pkg::FUNC_W-1:0] func;
    logic [olst_pkg::POS_W-1:0]  position;
    logic [olst_pkg::VAL_W-1:0]  element_value;
  } op_word_t;

  typedef struct packed {
    logic                        ok;
    logic [olst_pkg::VAL_W-1:0]  read_value;
    logic [olst_pkg::POS_W-1:0]  found_position;
    logic [olst_pkg::CNT_W-1:0]  list_length;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [olst_pkg::CAP_W-1:0] cfg_wdata = '0;

  olst_in_if  in_ch ();
  olst_out_if out_ch ();

  ordered_array_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  op_word_t    pending_ops[$];
  result_t     expected_results[$];
  logic [olst_pkg::VAL_W-1:0] value_pool[16];
  int          seg_caps[NUM_SEGS] = '{8, 128, 1, 255, 0, 100};

  // shadow of the list
  logic [olst_pkg::VAL_W-1:0] shadow_words[DEPTH];
  int          shadow_len = 0;
  int          shadow_cap = int'(olst_pkg::CAP_RESET);

  int          src_idle_pct = 26;
  int          sink_idle_pct = 77;
  bit          word_taken = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic result_t apply_list_op(op_word_t w);
    result_t r;
    int      eff_cap;
    int      p;
    int      i;
    r = '0;
    p = int'(w.position);
    eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (w.func)
      olst_pkg::OP_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < eff_cap) begin
          for (i = shadow_len; i >= p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p-1] = w.element_value;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      olst_pkg::OP_READ: begin
        if (p >= 1 && p <= shadow_len) begin
          r.read_value = shadow_words[p-1];
          r.ok = 1'b1;
        end
      end
      olst_pkg::OP_REMOVE: begin
        if (p >= 1 && p <= shadow_len) begin
          for (i = p - 1; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      olst_pkg::OP_FIND: begin
        r.found_position = (shadow_len + 1 > olst_pkg::CNT_MAX) ?
                           pos_t'(olst_pkg::CNT_MAX) : pos_t'(shadow_len + 1);
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == w.element_value) begin
            r.found_position = pos_t'(i + 1);
            break;
          end
        end
        r.ok = 1'b1;
      end
      olst_pkg::OP_CLEAR: begin
        shadow_len = 0;
        r.found_position = pos_t'(1);
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.list_length = shadow_len[olst_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic op_word_t random_op();
    op_word_t w;
    int       pick;
    int       span;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.func = olst_pkg::OP_INSERT;
    else if (pick < 60) w.func = olst_pkg::OP_READ;
    else if (pick < 78) w.func = olst_pkg::OP_REMOVE;
    else if (pick < 94) w.func = olst_pkg::OP_FIND;
    else if (pick < 96) w.func = olst_pkg::OP_CLEAR;
    else w.func = func_t'($urandom_range(int'(olst_pkg::OP_CLEAR) + 1, int'(OP_TOP)));
    span = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    if (span < 8) span = 8;
    pick = $urandom_range(0, 99);
    if (pick < 85)      w.position = pos_t'($urandom_range(1, span + 2));
    else if (pick < 90) w.position = '0;
    else                w.position = pos_t'($urandom);
    if ($urandom_range(0, 1)) w.element_value = value_pool[$urandom_range(0, 15)];
    else                      w.element_value = $urandom;
    return w;
  endfunction

  task automatic queue_op(func_t f, int p, logic [olst_pkg::VAL_W-1:0] v);
    op_word_t w;
    w.func = f;
    w.position = pos_t'(p);
    w.element_value = v;
    pending_ops.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(int cap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap[olst_pkg::CAP_W-1:0];
    shadow_cap = cap & 'hFF;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: request and ready change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      if (!in_ch.valid || word_taken) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.func <= pending_ops[0].func;
          in_ch.position <= pending_ops[0].position;
          in_ch.element_value <= pending_ops[0].element_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results are checked before the new request is predicted
  always @(posedge clk) begin : result_check
    result_t  got;
    result_t  want;
    op_word_t req;
    if (!rst_n) begin
      word_taken = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.ok = out_ch.ok;
        got.read_value = out_ch.read_value;
        got.found_position = out_ch.found_position;
        got.list_length = out_ch.list_length;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: ok %0b read_value %h found_position %0d len %0d",
                     got.ok, got.read_value, got.found_position, got.list_length);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.read_value !== want.read_value ||
              got.found_position !== want.found_position ||
              got.list_length !== want.list_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp/act: ok %0b/%0b rv %h/%h fp %0d/%0d len %0d/%0d",
                       want.ok, got.ok, want.read_value, got.read_value,
                       want.found_position, got.found_position,
                       want.list_length, got.list_length);
          end
        end
      end
      word_taken = in_ch.valid && in_ch.ready;
      if (word_taken) begin
        req.func = in_ch.func;
        req.position = in_ch.position;
        req.element_value = in_ch.element_value;
        void'(pending_ops.pop_front());
        expected_results.push_back(apply_list_op(req));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int n;
    in_ch.valid = 1'b0;
    in_ch.func = olst_pkg::OP_READ;
    in_ch.position = '0;
    in_ch.element_value = '0;
    out_ch.ready = 1'b0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (n = 2; n < 16; n++) value_pool[n] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list under the reset capacity
    queue_op(olst_pkg::OP_READ,   1, '0);
    queue_op(olst_pkg::OP_FIND,   0, 32'h1234_5678);
    queue_op(olst_pkg::OP_INSERT, 0, 32'hDEAD_BEEF);
    queue_op(olst_pkg::OP_INSERT, 2, 32'hDEAD_BEEF);
    queue_op(olst_pkg::OP_INSERT, 1, '0);
    queue_op(olst_pkg::OP_CLEAR,  0, '0);
    wait_drained();

    // small capacity: full list, misses, bad codes
    set_capacity(3);
    queue_op(olst_pkg::OP_INSERT, 1, '1);
    queue_op(olst_pkg::OP_INSERT, 1, '0);
    queue_op(olst_pkg::OP_INSERT, 3, 32'hA5A5_A5A5);
    queue_op(olst_pkg::OP_INSERT, 2, 32'h5A5A_5A5A);
    queue_op(olst_pkg::OP_READ,   1, '0);
    queue_op(olst_pkg::OP_READ,   3, '0);
    queue_op(olst_pkg::OP_READ,   4, '0);
    queue_op(olst_pkg::OP_READ,   0, '0);
    queue_op(olst_pkg::OP_FIND,   0, '1);
    queue_op(olst_pkg::OP_FIND,   0, 32'h1234_5678);
    queue_op(olst_pkg::OP_REMOVE, 0, '0);
    queue_op(olst_pkg::OP_REMOVE, 4, '0);
    queue_op(olst_pkg::OP_REMOVE, 2, '0);
    queue_op(olst_pkg::OP_FIND,   0, '1);
    queue_op(olst_pkg::OP_CLEAR + 3'd1, 1, '1);
    queue_op(olst_pkg::OP_CLEAR + 3'd2, 2, '0);
    queue_op(OP_TOP,              255, '1);
    queue_op(olst_pkg::OP_CLEAR,  0, '0);
    queue_op(olst_pkg::OP_REMOVE, 1, '0);
    queue_op(olst_pkg::OP_READ,   255, '0);
    wait_drained();

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin src_idle_pct = 26; sink_idle_pct = 77; end
        1: begin src_idle_pct = 77; sink_idle_pct = 26; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      set_capacity(seg_caps[seg]);
      for (n = 0; n < ITEMS_PER_SEG; n++) pending_ops.push_back(random_op());
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/olst_pkg.sv
rtl/olst_in_if.sv
rtl/olst_out_if.sv
rtl/olst_ram.sv
rtl/olst_ctrl.sv
rtl/ordered_array_list.sv
sim/tb_ordered_array_list.sv
